### sv/complex_exponential_unit_macros.svh
// ----------------------------------------------------------------------------
// complex_exponential_unit_macros.svh
// Assertion macros shared by the complex exponential unit modules.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_EXPONENTIAL_UNIT_MACROS_SVH
`define COMPLEX_EXPONENTIAL_UNIT_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define CEXP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define CEXP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cexp_pkg.sv
// ----------------------------------------------------------------------------
// cexp_pkg
// Widths, constants, beat types and the arctangent table of the complex
// exponential unit.
// ----------------------------------------------------------------------------
package cexp_pkg;

    // Field widths
    localparam int ANGLE_W          = 32;
    localparam int OUT_W            = 32;
    localparam int ANGLE_FRAC_SHIFT = 24;   // Q8.24 to Q8.48

    // Rotation stage count, limited to the arctangent table
    localparam int ROTATION_STAGES  = 28;
    localparam int ATAN_LEN         = 32;
    localparam int ATAN_IDX_W       = $clog2(ATAN_LEN);
    localparam int CORDIC_STAGES    = (ROTATION_STAGES > ATAN_LEN) ? ATAN_LEN
                                                                    : ROTATION_STAGES;

    // Range reduction: offset angle held unsigned in Q48
    localparam int REM_W            = 57;
    localparam int REDUCE_STEPS     = 6;
    localparam logic [REM_W-1:0] TWO_PI_REM = REM_W'(64'h6487ED5110B46);
    // 21 turns lift the most negative angle to zero or above
    localparam logic [REM_W-1:0] REM_OFFSET = TWO_PI_REM * REM_W'(21);

    // Wrap to [-pi, pi) and round to Q30
    localparam int WRAP_W           = 52;
    localparam int ROUND_SHIFT      = 18;
    localparam int Z_W              = WRAP_W - ROUND_SHIFT;
    localparam logic signed [WRAP_W-1:0] PI_WRAP     = WRAP_W'(64'h3243F6A8885A3);
    localparam logic signed [WRAP_W-1:0] TWO_PI_WRAP = WRAP_W'(64'h6487ED5110B46);
    localparam logic signed [WRAP_W-1:0] HALF_WRAP   = WRAP_W'(1) << (ROUND_SHIFT - 1);
    localparam logic signed [Z_W-1:0]    PI_Z        = Z_W'(64'hC90FDAA2);
    localparam logic signed [Z_W-1:0]    HALF_PI_Z   = Z_W'(64'h6487ED51);

    // Rotation datapath with guard bits
    localparam int GUARD_BITS       = 10;
    localparam int X_W              = 44;
    localparam int RES_W            = X_W - GUARD_BITS;
    localparam logic signed [X_W-1:0]   X_INIT  = X_W'(64'h26DD3B6A) << GUARD_BITS;
    localparam logic signed [X_W-1:0]   X_HALF  = X_W'(1) << (GUARD_BITS - 1);
    localparam logic signed [RES_W-1:0] ONE_RES = RES_W'(64'h40000000);

    // atan(2^-i) in Q2.30
    localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
        32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
    };

    // Folded angle beat into the rotation pipeline
    typedef struct packed {
        logic [Z_W-1:0] z;
        logic           flip;
    } t_rot_beat;

    // Rotated vector beat into the output stage
    typedef struct packed {
        logic [X_W-1:0] x;
        logic [X_W-1:0] y;
        logic           flip;
    } t_vec_beat;

endpackage

### sv/cexp_reduce.sv
// ----------------------------------------------------------------------------
// cexp_reduce
// Range reduction pipeline: scale to Q48, reduce modulo two pi by one
// conditional subtract per stage, wrap to [-pi, pi), round to Q30 and fold
// into [-pi/2, pi/2].
// ----------------------------------------------------------------------------
`include "complex_exponential_unit_macros.svh"

module cexp_reduce (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [cexp_pkg::ANGLE_W-1:0]    i_angle,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output cexp_pkg::t_rot_beat                    o_beat
);
    import cexp_pkg::*;

    // offset stage, subtract stages, wrap stage, fold stage
    localparam int NSTG = REDUCE_STEPS + 3;
    localparam int WRAP_STG = NSTG - 2;
    localparam int FOLD_STG = NSTG - 1;

    logic [NSTG-1:0]           r_vld;
    logic [NSTG-1:0]           n_vld;
    logic [NSTG-1:0]           en;
    logic [REM_W-1:0]          r_rem [REDUCE_STEPS+1];
    logic [REM_W-1:0]          n_rem [REDUCE_STEPS+1];
    logic [REM_W:0]            diff  [REDUCE_STEPS];
    logic signed [WRAP_W-1:0]  wrap_in;
    logic signed [WRAP_W-1:0]  wrap_sh;
    logic signed [WRAP_W-1:0]  wrap_rnd;
    logic signed [Z_W-1:0]     r_zw;
    logic signed [Z_W-1:0]     n_zw;
    logic signed [Z_W-1:0]     r_fz;
    logic signed [Z_W-1:0]     n_fz;
    logic                      r_flip;
    logic                      n_flip;

    // Stage enables: a stage moves when empty or when the next one moves
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[FOLD_STG];

    // Valid bits travel with the data
    always_comb begin
        n_vld[0] = i_valid;
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Scale to Q48 and add whole turns so the value is never negative
    always_comb begin
        n_rem[0] = (REM_W'(i_angle) << ANGLE_FRAC_SHIFT) + REM_OFFSET;
        for (int j = 0; j < REDUCE_STEPS; j++) begin
            diff[j] = {1'b0, r_rem[j]} - {1'b0, TWO_PI_REM << (REDUCE_STEPS - 1 - j)};
            n_rem[j+1] = diff[j][REM_W] ? r_rem[j] : diff[j][REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= REDUCE_STEPS; j++) begin
            if (en[j]) begin
                r_rem[j] <= n_rem[j];
            end
        end
    end

    // Wrap into [-pi, pi) and round half up to Q30
    always_comb begin
        wrap_in  = signed'(r_rem[REDUCE_STEPS][WRAP_W-1:0]);
        wrap_sh  = (wrap_in >= PI_WRAP) ? wrap_in - TWO_PI_WRAP : wrap_in;
        wrap_rnd = wrap_sh + HALF_WRAP;
        n_zw     = signed'(wrap_rnd[WRAP_W-1:ROUND_SHIFT]);
    end

    // Fold into [-pi/2, pi/2], flipping both outputs
    always_comb begin
        if (r_zw > HALF_PI_Z) begin
            n_fz   = r_zw - PI_Z;
            n_flip = 1'b1;
        end else if (r_zw < -HALF_PI_Z) begin
            n_fz   = r_zw + PI_Z;
            n_flip = 1'b1;
        end else begin
            n_fz   = r_zw;
            n_flip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[WRAP_STG]) begin
            r_zw <= n_zw;
        end
        if (en[FOLD_STG]) begin
            r_fz   <= n_fz;
            r_flip <= n_flip;
        end
    end

    assign o_beat.z    = r_fz;
    assign o_beat.flip = r_flip;

    `CEXP_ASSERT_IMPLY(a_rem_bound, r_vld[REDUCE_STEPS], r_rem[REDUCE_STEPS] < TWO_PI_REM, "remainder not below two pi")
    `CEXP_ASSERT_IMPLY(a_wrap_bound, r_vld[WRAP_STG], (r_zw <= PI_Z) && (r_zw >= -PI_Z), "wrapped angle beyond pi")
    `CEXP_ASSERT_IMPLY(a_fold_bound, r_vld[FOLD_STG], (r_fz <= HALF_PI_Z) && (r_fz >= -HALF_PI_Z), "folded angle beyond half pi")

endmodule

### sv/cexp_cordic.sv
// ----------------------------------------------------------------------------
// cexp_cordic
// Rotation pipeline: one CORDIC micro-rotation per register stage, starting
// from the gain-corrected unit vector on the real axis.
// ----------------------------------------------------------------------------
module cexp_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  cexp_pkg::t_rot_beat  i_beat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output cexp_pkg::t_vec_beat  o_beat
);
    import cexp_pkg::*;

    logic [CORDIC_STAGES-1:0]  r_vld;
    logic [CORDIC_STAGES-1:0]  n_vld;
    logic [CORDIC_STAGES-1:0]  en;
    logic signed [X_W-1:0]     r_x    [CORDIC_STAGES];
    logic signed [X_W-1:0]     r_y    [CORDIC_STAGES];
    logic signed [Z_W-1:0]     r_z    [CORDIC_STAGES];
    logic                      r_flip [CORDIC_STAGES];
    logic signed [X_W-1:0]     sx     [CORDIC_STAGES];
    logic signed [X_W-1:0]     sy     [CORDIC_STAGES];
    logic signed [Z_W-1:0]     sz     [CORDIC_STAGES];
    logic                      sflip  [CORDIC_STAGES];
    logic signed [Z_W-1:0]     atan_z [CORDIC_STAGES];
    logic signed [X_W-1:0]     n_x    [CORDIC_STAGES];
    logic signed [X_W-1:0]     n_y    [CORDIC_STAGES];
    logic signed [Z_W-1:0]     n_z    [CORDIC_STAGES];

    // Stage enables
    always_comb begin
        en[CORDIC_STAGES-1] = !r_vld[CORDIC_STAGES-1] || i_ready;
        for (int k = CORDIC_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[CORDIC_STAGES-1];

    always_comb begin
        n_vld[0] = i_valid;
        for (int k = 1; k < CORDIC_STAGES; k++) begin
            n_vld[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Pick each stage's source: the incoming beat for the first stage
    always_comb begin
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (i == 0) begin
                sx[i]    = X_INIT;
                sy[i]    = '0;
                sz[i]    = signed'(i_beat.z);
                sflip[i] = i_beat.flip;
            end else begin
                sx[i]    = r_x[i-1];
                sy[i]    = r_y[i-1];
                sz[i]    = r_z[i-1];
                sflip[i] = r_flip[i-1];
            end
        end
    end

    // Rotate towards zero residual angle
    always_comb begin
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            atan_z[i] = signed'(Z_W'(ATAN_Q30[ATAN_IDX_W'(i)]));
            if (!sz[i][Z_W-1]) begin
                n_x[i] = sx[i] - (sy[i] >>> i);
                n_y[i] = sy[i] + (sx[i] >>> i);
                n_z[i] = sz[i] - atan_z[i];
            end else begin
                n_x[i] = sx[i] + (sy[i] >>> i);
                n_y[i] = sy[i] - (sx[i] >>> i);
                n_z[i] = sz[i] + atan_z[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (en[i]) begin
                r_x[i]    <= n_x[i];
                r_y[i]    <= n_y[i];
                r_z[i]    <= n_z[i];
                r_flip[i] <= sflip[i];
            end
        end
    end

    assign o_beat.x    = r_x[CORDIC_STAGES-1];
    assign o_beat.y    = r_y[CORDIC_STAGES-1];
    assign o_beat.flip = r_flip[CORDIC_STAGES-1];

endmodule

### sv/cexp_round.sv
// ----------------------------------------------------------------------------
// cexp_round
// Output stages: drop the guard bits with round half up, undo the fold and
// clamp both parts to the Q1.30 range in the output register.
// ----------------------------------------------------------------------------
`include "complex_exponential_unit_macros.svh"

module cexp_round (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  cexp_pkg::t_vec_beat                 i_beat,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [cexp_pkg::OUT_W-1:0]   o_cos_part,
    output logic signed [cexp_pkg::OUT_W-1:0]   o_sin_part
);
    import cexp_pkg::*;

    localparam int NSTG = 2;

    logic [NSTG-1:0]           r_vld;
    logic [NSTG-1:0]           en;
    logic signed [X_W-1:0]     cx_rnd;
    logic signed [X_W-1:0]     cy_rnd;
    logic signed [RES_W-1:0]   r_c;
    logic signed [RES_W-1:0]   r_s;
    logic                      r_flip;
    logic signed [RES_W-1:0]   c_neg;
    logic signed [RES_W-1:0]   s_neg;
    logic signed [OUT_W-1:0]   n_cos;
    logic signed [OUT_W-1:0]   n_sin;
    logic signed [OUT_W-1:0]   r_cos;
    logic signed [OUT_W-1:0]   r_sin;

    // Stage enables: the output register frees when its beat is taken
    assign en[1]   = !r_vld[1] || i_ready;
    assign en[0]   = !r_vld[0] || en[1];
    assign o_ready = en[0];
    assign o_valid = r_vld[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            if (en[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    // Round half up and drop the guard bits
    always_comb begin
        cx_rnd = signed'(i_beat.x) + X_HALF;
        cy_rnd = signed'(i_beat.y) + X_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_c    <= signed'(cx_rnd[X_W-1:GUARD_BITS]);
            r_s    <= signed'(cy_rnd[X_W-1:GUARD_BITS]);
            r_flip <= i_beat.flip;
        end
    end

    // Undo the fold and saturate at plus or minus one
    always_comb begin
        c_neg = r_flip ? -r_c : r_c;
        s_neg = r_flip ? -r_s : r_s;
        if (c_neg > ONE_RES) begin
            n_cos = OUT_W'(ONE_RES);
        end else if (c_neg < -ONE_RES) begin
            n_cos = OUT_W'(-ONE_RES);
        end else begin
            n_cos = OUT_W'(c_neg);
        end
        if (s_neg > ONE_RES) begin
            n_sin = OUT_W'(ONE_RES);
        end else if (s_neg < -ONE_RES) begin
            n_sin = OUT_W'(-ONE_RES);
        end else begin
            n_sin = OUT_W'(s_neg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_cos_part = r_cos;
    assign o_sin_part = r_sin;

    `CEXP_ASSERT_IMPLY(a_cos_range, r_vld[1], (r_cos <= OUT_W'(ONE_RES)) && (r_cos >= OUT_W'(-ONE_RES)), "cosine outside Q1.30 range")
    `CEXP_ASSERT_IMPLY(a_sin_range, r_vld[1], (r_sin <= OUT_W'(ONE_RES)) && (r_sin >= OUT_W'(-ONE_RES)), "sine outside Q1.30 range")
    `CEXP_ASSERT_NEXT(a_stage_hold, r_vld[0] && r_vld[1] && !i_ready, r_vld[0], "stalled beat lost from round stage")

endmodule

### sv/complex_exponential_unit.sv
// ----------------------------------------------------------------------------
// complex_exponential_unit
// An accepted angle passes 9 range reduction stages, 28 rotation stages
// and 2 output stages on its way to the output.
// Throughput: one angle per cycle; every stage is registered and a stall
// holds each beat in place while empty stages keep filling.
// Reset clears the valid bits only; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module complex_exponential_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [cexp_pkg::ANGLE_W-1:0] i_angle,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [cexp_pkg::OUT_W-1:0]   o_cos_part,
    output logic signed [cexp_pkg::OUT_W-1:0]   o_sin_part
);
    import cexp_pkg::*;

    logic       red_valid;
    logic       cor_ready;
    t_rot_beat  red_beat;
    logic       cor_valid;
    logic       rnd_ready;
    t_vec_beat  cor_beat;

    // Reduce the angle modulo two pi and fold it
    cexp_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_angle (i_angle),
        .o_valid (red_valid),
        .i_ready (cor_ready),
        .o_beat  (red_beat)
    );

    // Rotate the unit vector
    cexp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (red_valid),
        .o_ready (cor_ready),
        .i_beat  (red_beat),
        .o_valid (cor_valid),
        .i_ready (rnd_ready),
        .o_beat  (cor_beat)
    );

    // Round, unfold, clamp and hold the result beat
    cexp_round u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (cor_valid),
        .o_ready    (rnd_ready),
        .i_beat     (cor_beat),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_cos_part (o_cos_part),
        .o_sin_part (o_sin_part)
    );

endmodule
